// File: hdl/twe_pkg.sv
// Package for the tape record wave encoder: codes, record and queue sizes,
// shared structs. No dependencies.
`timescale 1ns / 1ps

package twe_pkg;

	// Record geometry
	localparam int RECORD_BYTES = 192;
	localparam int SYNC_PAIRS   = 60;
	localparam int ADDR_W       = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;

	// Front queue
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Request codes on the req_type port
	localparam logic [1:0] REQ_LOAD  = 2'd0;
	localparam logic [1:0] REQ_START = 2'd1;
	localparam logic [1:0] REQ_PULL  = 2'd2;

	// Register indexes (byte address 4*i)
	localparam logic [1:0] REG_SHORT  = 2'd0;
	localparam logic [1:0] REG_MEDIUM = 2'd1;
	localparam logic [1:0] REG_LONG   = 2'd2;

	// Countdown bases and byte-level wave positions
	localparam logic [7:0] CD1_BASE    = 8'h89;
	localparam logic [7:0] CD2_BASE    = 8'h09;
	localparam logic [7:0] CD_LAST_CNT = 8'd8;
	localparam logic [4:0] WAVE_LAST   = 5'd19;
	localparam logic [4:0] WAVE_PARITY = 5'd18;

	typedef enum logic [1:0] {
		K_SHORT  = 2'd0,
		K_MEDIUM = 2'd1,
		K_LONG   = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		PH_IDLE  = 4'd0,
		PH_CD1   = 4'd1,
		PH_DATA1 = 4'd2,
		PH_SUM1  = 4'd3,
		PH_MARK1 = 4'd4,
		PH_SYNC1 = 4'd5,
		PH_CD2   = 4'd6,
		PH_DATA2 = 4'd7,
		PH_SUM2  = 4'd8,
		PH_MARK2 = 4'd9,
		PH_SYNC2 = 4'd10
	} phase_t;

	// Classified operation held in the queue
	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_START = 2'd1,
		OP_PULL  = 2'd2
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
		logic              eod;
	} q_item_t;

	typedef struct packed {
		logic    valid;
		q_item_t item;
	} q_head_t;

	typedef struct packed {
		logic [15:0] short_ticks;
		logic [15:0] medium_ticks;
		logic [15:0] long_ticks;
	} twe_cfg_t;

endpackage

// File: hdl/twe_front.sv
// Front end: takes request items, decodes them and queues the useful ones.
// Depends on twe_pkg.
`timescale 1ns / 1ps

module twe_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [1:0]       req_type,
	input  logic [7:0]       byte_index,
	input  logic [7:0]       data_byte,
	input  logic             end_of_data,
	output twe_pkg::q_head_t head
);
	import twe_pkg::*;

	q_item_t           entry_q [QDEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QCNT_W-1:0] count_q;

	q_item_t cls;
	logic    keep;
	logic    push;
	logic    pop;

	// Decode: out-of-range loads and the unused code are dropped here
	always_comb begin
		cls.op   = OP_PULL;
		cls.addr = byte_index[ADDR_W-1:0];
		cls.data = data_byte;
		cls.eod  = end_of_data;
		keep     = 1'b0;
		unique case (req_type)
			REQ_LOAD: begin
				cls.op = OP_LOAD;
				keep   = ({1'b0, byte_index} < 9'(RECORD_BYTES));
			end
			REQ_START: begin
				cls.op = OP_START;
				keep   = 1'b1;
			end
			REQ_PULL: begin
				cls.op = OP_PULL;
				keep   = 1'b1;
			end
			default: keep = 1'b0;
		endcase
	end

	assign busy = (count_q == QCNT_W'(QDEPTH));
	assign push = start && !busy && keep;
	// The back end takes one item every cycle
	assign pop  = (count_q != '0);

	assign head.valid = pop;
	assign head.item  = entry_q[rptr_q];

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wptr_q] <= cls;
		end
	end

	// Queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: hdl/twe_back.sv
// Back end: record store, wave sequencer and registered result.
// Depends on twe_pkg.
`timescale 1ns / 1ps

module twe_back (
	input  logic              clk,
	input  logic              arst_n,
	input  twe_pkg::q_head_t  head,
	input  twe_pkg::twe_cfg_t cfg,
	output logic              done,
	output logic [15:0]       wave_ticks,
	output logic [1:0]        wave_kind,
	output logic              last_wave
);
	import twe_pkg::*;

	// Record store and its registered read port
	logic [7:0] store_q [RECORD_BYTES];
	logic [7:0] rd_q;

	// Sequencer state
	phase_t     phase_q, phase_d;
	logic [7:0] cnt_q, cnt_d;
	logic [4:0] wave_q, wave_d;
	logic [7:0] shift_q, shift_d;
	logic [7:0] sum_q, sum_d;
	logic [6:0] pilot_q, pilot_d;
	logic       final_q, final_d;
	logic       fetch_q, fetch_d;

	// Result
	logic        done_q;
	kind_t       kind_q;
	logic [15:0] ticks_q;
	logic        last_q;

	logic        emit;
	kind_t       kind;
	logic        last;
	logic        we;
	logic [7:0]  pilot_inc;
	logic [15:0] ticks;

	// Kind of wave w of a byte: marker, eight bits LSB first, parity
	function automatic kind_t byte_wave(input logic [4:0] w, input logic [7:0] b);
		logic bitv;
		begin
			bitv = (w >= WAVE_PARITY) ? ~^b : b[3'(w[4:1] - 4'd1)];
			if (w == 5'd0) begin
				byte_wave = K_LONG;
			end else if (w == 5'd1) begin
				byte_wave = K_MEDIUM;
			end else if (bitv) begin
				byte_wave = w[0] ? K_SHORT : K_MEDIUM;
			end else begin
				byte_wave = w[0] ? K_MEDIUM : K_SHORT;
			end
		end
	endfunction

	assign pilot_inc = {1'b0, pilot_q} + 8'd1;

	// Next state and result
	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		wave_d  = wave_q;
		shift_d = shift_q;
		sum_d   = sum_q;
		pilot_d = pilot_q;
		final_d = final_q;
		fetch_d = 1'b0;
		emit    = 1'b0;
		kind    = K_SHORT;
		last    = 1'b0;
		we      = 1'b0;

		// Data byte read last cycle lands in the shift register and checksum
		if (fetch_q) begin
			shift_d = rd_q;
			sum_d   = sum_q ^ rd_q;
		end

		if (head.valid) begin
			unique case (head.item.op)
				OP_LOAD: we = 1'b1;
				OP_START: begin
					phase_d = PH_CD1;
					cnt_d   = '0;
					wave_d  = '0;
					shift_d = '0;
					sum_d   = '0;
					pilot_d = '0;
					final_d = head.item.eod;
				end
				OP_PULL: begin
					if (phase_q != PH_IDLE) begin
						emit = 1'b1;
						unique case (phase_q)
							PH_MARK1: begin
								kind    = K_LONG;
								phase_d = PH_SYNC1;
								pilot_d = '0;
								wave_d  = '0;
							end
							PH_MARK2: begin
								if (wave_q == 5'd0) begin
									kind = K_LONG;
									if (final_q) begin
										wave_d = 5'd1;
									end else begin
										phase_d = PH_SYNC2;
										pilot_d = '0;
										wave_d  = '0;
									end
								end else begin
									kind    = K_SHORT;
									phase_d = PH_SYNC2;
									pilot_d = '0;
									wave_d  = '0;
								end
							end
							PH_SYNC1, PH_SYNC2: begin
								kind = K_SHORT;
								if (wave_q == 5'd0) begin
									wave_d = 5'd1;
								end else begin
									wave_d = '0;
									if (pilot_inc >= 8'(SYNC_PAIRS)) begin
										pilot_d = '0;
										if (phase_q == PH_SYNC1) begin
											phase_d = PH_CD2;
											cnt_d   = '0;
										end else begin
											phase_d = PH_IDLE;
											last    = 1'b1;
										end
									end else begin
										pilot_d = pilot_inc[6:0];
									end
								end
							end
							default: begin
								// Byte phases: countdown, data, checksum
								if (wave_q == 5'd0) begin
									unique case (phase_q)
										PH_CD1: shift_d = CD1_BASE - cnt_q;
										PH_CD2: shift_d = CD2_BASE - cnt_q;
										PH_DATA1, PH_DATA2: fetch_d = 1'b1;
										default: shift_d = sum_q;
									endcase
								end
								kind = byte_wave(wave_q, shift_q);
								if (wave_q >= WAVE_LAST) begin
									wave_d = '0;
									unique case (phase_q)
										PH_CD1, PH_CD2: begin
											if (cnt_q >= CD_LAST_CNT) begin
												phase_d = phase_t'(phase_q + 4'd1);
												cnt_d   = '0;
												sum_d   = '0;
											end else begin
												cnt_d = cnt_q + 8'd1;
											end
										end
										PH_DATA1, PH_DATA2: begin
											if ({1'b0, cnt_q} + 9'd1 >= 9'(RECORD_BYTES)) begin
												phase_d = phase_t'(phase_q + 4'd1);
											end else begin
												cnt_d = cnt_q + 8'd1;
											end
										end
										default: phase_d = phase_t'(phase_q + 4'd1);
									endcase
								end else begin
									wave_d = wave_q + 5'd1;
								end
							end
						endcase
					end
				end
				default: emit = 1'b0;
			endcase
		end
	end

	// Duration from the register of the chosen kind
	always_comb begin
		case (kind)
			K_LONG:   ticks = cfg.long_ticks;
			K_MEDIUM: ticks = cfg.medium_ticks;
			default:  ticks = cfg.short_ticks;
		endcase
	end

	// Record store: write on load, read at the byte counter on a data fetch
	always_ff @(posedge clk) begin
		if (we) begin
			store_q[head.item.addr] <= head.item.data;
		end
		if (fetch_d) begin
			rd_q <= store_q[cnt_q[ADDR_W-1:0]];
		end
	end

	// Sequencer and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= '0;
			wave_q  <= '0;
			shift_q <= '0;
			sum_q   <= '0;
			pilot_q <= '0;
			final_q <= 1'b0;
			fetch_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			wave_q  <= wave_d;
			shift_q <= shift_d;
			sum_q   <= sum_d;
			pilot_q <= pilot_d;
			final_q <= final_d;
			fetch_q <= fetch_d;
			done_q  <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			kind_q  <= kind;
			ticks_q <= ticks;
			last_q  <= last;
		end
	end

	assign done       = done_q;
	assign wave_ticks = ticks_q;
	assign wave_kind  = kind_q;
	assign last_wave  = done_q && last_q;

endmodule

// File: hdl/tape_record_wave_encoder.sv
// Top level of the tape record wave encoder: register port, front end and
// back end. Depends on twe_pkg, twe_front and twe_back.
`timescale 1ns / 1ps

// Load the record bytes (req_type 0), arm with a start (req_type 1), then
// request one wave per item (req_type 2); each wave request while a record is
// being sent gives one result on the done strobe, and the record is sent as
// two copies as usual for this tape format. Results cannot be held off: done
// is high for exactly one cycle, raised from the back end's result register
// once the request has left the queue, and the result is taken at the clock
// edge that ends it. Items are taken one per clock cycle through a two-entry
// queue that the back-end sequencer drains every cycle; a data byte is read
// from the store on its first wave and is used from its third wave on. Store
// entries that were never loaded read as undefined; there is no clearing
// after reset. Change the tick registers only while no request is in flight.
module tape_record_wave_encoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic [7:0]  byte_index,
	input  logic [7:0]  data_byte,
	input  logic        end_of_data,
	output logic        done,
	output logic [15:0] wave_ticks,
	output logic [1:0]  wave_kind,
	output logic        last_wave,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import twe_pkg::*;

	twe_cfg_t   cfg_q;
	q_head_t    head;
	logic       cfg_wr;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite;

	// Tick registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_ticks  <= 16'd48;
			cfg_q.medium_ticks <= 16'd68;
			cfg_q.long_ticks   <= 16'd86;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_SHORT:  cfg_q.short_ticks  <= pwdata[15:0];
				REG_MEDIUM: cfg_q.medium_ticks <= pwdata[15:0];
				REG_LONG:   cfg_q.long_ticks   <= pwdata[15:0];
				default:    ;
			endcase
		end
	end

	// Read-back
	always_comb begin
		unique case (reg_idx)
			REG_SHORT:  prdata = {16'd0, cfg_q.short_ticks};
			REG_MEDIUM: prdata = {16'd0, cfg_q.medium_ticks};
			REG_LONG:   prdata = {16'd0, cfg_q.long_ticks};
			default:    prdata = '0;
		endcase
	end

	twe_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req_type    (req_type),
		.byte_index  (byte_index),
		.data_byte   (data_byte),
		.end_of_data (end_of_data),
		.head        (head)
	);

	twe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.cfg        (cfg_q),
		.done       (done),
		.wave_ticks (wave_ticks),
		.wave_kind  (wave_kind),
		.last_wave  (last_wave)
	);

`ifndef SYNTH
	// A result only follows a wave request that left the queue in the previous cycle
	a_done_after_pull: assert property (@(posedge clk) disable iff (!arst_n)
		!(head.valid && head.item.op == OP_PULL) |=> !done)
		else $error("result without a preceding wave request");

	// The record always ends on the second short wave of a sync pair
	a_last_is_short: assert property (@(posedge clk) disable iff (!arst_n)
		(done && last_wave) |-> (wave_kind == K_SHORT))
		else $error("final wave of a record is not short");

	// A register write to the long tick register lands in that register
	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_wr && reg_idx == REG_LONG) |=> (cfg_q.long_ticks == $past(pwdata[15:0])))
		else $error("long tick register write lost");
`endif

endmodule
